[hdl/lcs_pkg.sv]
package lcs_pkg;

    localparam int PIXELS_PER_LINE_DEF = 16;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int DRIVE_W     = 9;
    localparam int STEER_W     = 13;
    localparam int DT_W        = 16;
    localparam int SPD_W       = 24;
    localparam int DRV_STEPS   = 10;

    localparam logic [7:0]  THRESH_RST = 8'd100;
    localparam logic [15:0] P_GAIN_RST = 16'd1920;
    localparam logic [15:0] D_GAIN_RST = 16'd1080;
    localparam logic [7:0]  SPEED_RST  = 8'd45;

    typedef enum logic [CFG_AW-1:0] {
        CFG_THRESH,
        CFG_P_GAIN,
        CFG_D_GAIN,
        CFG_BASE_SPEED
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  white_threshold;
        logic [15:0] p_gain;
        logic [15:0] d_gain;
        logic [7:0]  base_speed;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_START,
        OP_DIV,
        OP_EDONE,
        OP_MUL_P,
        OP_MUL_PT,
        OP_MUL_D,
        OP_ADD_D,
        OP_SUM_L,
        OP_LOAD_DIV,
        OP_LDONE,
        OP_RDONE,
        OP_EMIT,
        OP_ACCUM
    } op_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_NO_WHITE,
        JC_DIV_BUSY,
        JC_OUT_BUSY,
        JC_NOT_LINE_END
    } jcond_t;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UA_START  = 4'd0;
    localparam upc_t UA_EDIV   = 4'd1;
    localparam upc_t UA_EDONE  = 4'd2;
    localparam upc_t UA_MUL_P  = 4'd3;
    localparam upc_t UA_MUL_PT = 4'd4;
    localparam upc_t UA_MUL_D  = 4'd5;
    localparam upc_t UA_ADD_D  = 4'd6;
    localparam upc_t UA_SUM_L  = 4'd7;
    localparam upc_t UA_LLOAD  = 4'd8;
    localparam upc_t UA_LDIV   = 4'd9;
    localparam upc_t UA_LDONE  = 4'd10;
    localparam upc_t UA_RLOAD  = 4'd11;
    localparam upc_t UA_RDIV   = 4'd12;
    localparam upc_t UA_RDONE  = 4'd13;
    localparam upc_t UA_EMIT   = 4'd14;
    localparam upc_t UA_ACCUM  = 4'd15;
    localparam upc_t UA_LAST   = UA_ACCUM;

    typedef struct packed {
        op_t    op;
        jcond_t jc;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        logic no_white;
        logic div_busy;
        logic out_busy;
        logic not_line_end;
    } uflags_t;

    function automatic uword_t urom(upc_t addr);
        uword_t w;
        case (addr)
            UA_START:  w = '{OP_START,    JC_NO_WHITE,     UA_EMIT};
            UA_EDIV:   w = '{OP_DIV,      JC_DIV_BUSY,     UA_EDIV};
            UA_EDONE:  w = '{OP_EDONE,    JC_NEVER,        UA_START};
            UA_MUL_P:  w = '{OP_MUL_P,    JC_NEVER,        UA_START};
            UA_MUL_PT: w = '{OP_MUL_PT,   JC_NEVER,        UA_START};
            UA_MUL_D:  w = '{OP_MUL_D,    JC_NEVER,        UA_START};
            UA_ADD_D:  w = '{OP_ADD_D,    JC_NEVER,        UA_START};
            UA_SUM_L:  w = '{OP_SUM_L,    JC_NEVER,        UA_START};
            UA_LLOAD:  w = '{OP_LOAD_DIV, JC_NEVER,        UA_START};
            UA_LDIV:   w = '{OP_DIV,      JC_DIV_BUSY,     UA_LDIV};
            UA_LDONE:  w = '{OP_LDONE,    JC_NEVER,        UA_START};
            UA_RLOAD:  w = '{OP_LOAD_DIV, JC_NEVER,        UA_START};
            UA_RDIV:   w = '{OP_DIV,      JC_DIV_BUSY,     UA_RDIV};
            UA_RDONE:  w = '{OP_RDONE,    JC_NEVER,        UA_START};
            UA_EMIT:   w = '{OP_EMIT,     JC_OUT_BUSY,     UA_EMIT};
            UA_ACCUM:  w = '{OP_ACCUM,    JC_NOT_LINE_END, UA_ACCUM};
            default:   w = '{OP_ACCUM,    JC_NOT_LINE_END, UA_ACCUM};
        endcase
        return w;
    endfunction

endpackage

[hdl/lcs_useq.sv]
module lcs_useq (
    input  logic             aclk,
    input  logic             aresetn,
    input  lcs_pkg::uflags_t flags,
    output lcs_pkg::uword_t  uw
);

    lcs_pkg::upc_t upc_reg;
    lcs_pkg::upc_t upc_next;
    logic          take_jump;

    assign uw = lcs_pkg::urom(upc_reg);

    always_comb begin
        case (uw.jc)
            lcs_pkg::JC_NEVER:        take_jump = 1'b0;
            lcs_pkg::JC_NO_WHITE:     take_jump = flags.no_white;
            lcs_pkg::JC_DIV_BUSY:     take_jump = flags.div_busy;
            lcs_pkg::JC_OUT_BUSY:     take_jump = flags.out_busy;
            lcs_pkg::JC_NOT_LINE_END: take_jump = flags.not_line_end;
            default:                  take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (take_jump) begin
            upc_next = uw.target;
        end else if (upc_reg == lcs_pkg::UA_LAST) begin
            upc_next = lcs_pkg::UA_START;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= lcs_pkg::UA_ACCUM;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

[hdl/lcs_dpath.sv]
module lcs_dpath #(
    parameter int PIXELS_PER_LINE = lcs_pkg::PIXELS_PER_LINE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lcs_pkg::uword_t                   uw,
    input  lcs_pkg::cfg_t                     cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lcs_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lcs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output lcs_pkg::uflags_t                  flags
);

    localparam int PW   = $clog2(PIXELS_PER_LINE);
    localparam int HALF = PIXELS_PER_LINE / 2;
    localparam int MAXW = PIXELS_PER_LINE - HALF;
    localparam int SUMW = $clog2(MAXW * (MAXW + 1) / 2 + 1) + 1;
    localparam int CNTW = $clog2(PIXELS_PER_LINE + 1);
    localparam int QB   = $clog2(MAXW * 256 + 1);
    localparam int EW   = QB + 1;
    localparam int TW   = EW + 18;
    localparam int NW   = EW + 34;
    localparam int QW   = (QB > lcs_pkg::DRV_STEPS) ? QB : lcs_pkg::DRV_STEPS;
    localparam int DCW  = $clog2(QW);
    localparam int DW   = lcs_pkg::DRIVE_W;
    localparam int DRV_SHIFT = 16 + lcs_pkg::DRV_STEPS - 1;
    localparam int PAD_W = lcs_pkg::OUT_TDATA_W - 2 * DW - lcs_pkg::STEER_W;

    logic [PW-1:0]                pos_reg,   pos_next;
    logic signed [SUMW-1:0]       sum_reg,   sum_next;
    logic [CNTW-1:0]              cnt_reg,   cnt_next;
    logic signed [EW-1:0]         prev_reg,  prev_next;
    logic                         first_reg, first_next;
    logic                         mval_reg,  mval_next;

    logic [lcs_pkg::DT_W-1:0]     dt_reg,    dt_next;
    logic signed [EW-1:0]         err_reg,   err_next;
    logic                         seen_reg,  seen_next;
    logic signed [DW-1:0]         left_reg,  left_next;
    logic signed [DW-1:0]         right_reg, right_next;
    logic [lcs_pkg::SPD_W-1:0]    spd_reg,   spd_next;
    logic signed [TW-1:0]         t_reg,     t_next;
    logic signed [NW-1:0]         acc_reg,   acc_next;
    logic signed [NW-1:0]         nsum_reg,  nsum_next;
    logic [NW-1:0]                rem_reg,   rem_next;
    logic [NW-1:0]                sd_reg,    sd_next;
    logic [QW-1:0]                q_reg,     q_next;
    logic                         neg_reg,   neg_next;
    logic [DCW-1:0]               dcnt_reg,  dcnt_next;
    logic signed [DW-1:0]         oleft_reg,  oleft_next;
    logic signed [DW-1:0]         oright_reg, oright_next;
    logic signed [lcs_pkg::STEER_W-1:0] oerr_reg, oerr_next;
    logic                         oseen_reg, oseen_next;

    logic [7:0]                   pixel;
    logic [lcs_pkg::DT_W-1:0]     elapsed;
    logic                         accept;
    logic                         last_px;
    logic                         white;
    logic                         out_busy;
    logic signed [SUMW-1:0]       wgt;
    logic [SUMW-1:0]              abs_sum;
    logic [NW-1:0]                abs_nsum;
    logic signed [EW:0]           diff;
    logic signed [NW-1:0]         spd_sh;
    logic [7:0]                   drv_mag;
    logic signed [DW-1:0]         drv_val;
    logic [9:0]                   rev_full;
    logic [7:0]                   rev_mag;
    logic signed [DW-1:0]         rev_val;
    logic [QB-1:0]                err_mag;

    assign pixel    = s_tdata[7:0];
    assign elapsed  = s_tdata[lcs_pkg::IN_TDATA_W-1:8];
    assign s_tready = (uw.op == lcs_pkg::OP_ACCUM);
    assign accept   = s_tvalid && s_tready;
    assign last_px  = s_tlast || (pos_reg == PW'(PIXELS_PER_LINE - 1));
    assign white    = pixel > cfg.white_threshold;
    assign out_busy = mval_reg && !m_tready;

    assign wgt = SUMW'(int'(pos_reg) - HALF + ((pos_reg >= PW'(HALF)) ? 1 : 0));

    assign abs_sum  = sum_reg[SUMW-1] ? unsigned'(-sum_reg) : unsigned'(sum_reg);
    assign abs_nsum = nsum_reg[NW-1] ? unsigned'(-nsum_reg) : unsigned'(nsum_reg);
    assign diff     = (EW + 1)'(err_reg) - (EW + 1)'(prev_reg);
    assign spd_sh   = signed'(NW'(spd_reg) << 16);

    assign drv_mag  = (q_reg > QW'(255)) ? 8'hFF : q_reg[7:0];
    assign drv_val  = neg_reg ? -signed'({1'b0, drv_mag}) : signed'({1'b0, drv_mag});
    assign rev_full = (10'(cfg.base_speed) * 10'd3) >> 1;
    assign rev_mag  = (rev_full > 10'd255) ? 8'hFF : rev_full[7:0];
    assign rev_val  = -signed'({1'b0, rev_mag});
    assign err_mag  = q_reg[QB-1:0];

    assign flags.no_white     = (cnt_reg == '0);
    assign flags.div_busy     = (dcnt_reg != '0);
    assign flags.out_busy     = out_busy;
    assign flags.not_line_end = !(s_tvalid && last_px);

    assign m_tvalid = mval_reg;
    assign m_tuser  = oseen_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, oerr_reg, oright_reg, oleft_reg};

    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        mval_next   = out_busy;
        dt_next     = dt_reg;
        err_next    = err_reg;
        seen_next   = seen_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        spd_next    = spd_reg;
        t_next      = t_reg;
        acc_next    = acc_reg;
        nsum_next   = nsum_reg;
        rem_next    = rem_reg;
        sd_next     = sd_reg;
        q_next      = q_reg;
        neg_next    = neg_reg;
        dcnt_next   = dcnt_reg;
        oleft_next  = oleft_reg;
        oright_next = oright_reg;
        oerr_next   = oerr_reg;
        oseen_next  = oseen_reg;

        case (uw.op)
            lcs_pkg::OP_ACCUM: begin
                if (accept) begin
                    if (white) begin
                        sum_next = sum_reg + wgt;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (last_px) begin
                        dt_next = (first_reg || elapsed == '0) ? lcs_pkg::DT_W'(1) : elapsed;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            lcs_pkg::OP_START: begin
                // preset the no-line answer, start the centroid division
                seen_next  = (cnt_reg != '0);
                err_next   = '0;
                left_next  = rev_val;
                right_next = rev_val;
                spd_next   = lcs_pkg::SPD_W'(cfg.base_speed) * lcs_pkg::SPD_W'(dt_reg);
                rem_next   = NW'(abs_sum) << 8;
                neg_next   = sum_reg[SUMW-1];
                sd_next    = NW'(cnt_reg) << (QB - 1);
                q_next     = '0;
                dcnt_next  = DCW'(QB - 1);
            end
            lcs_pkg::OP_DIV: begin
                if (rem_reg >= sd_reg) begin
                    rem_next = rem_reg - sd_reg;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end else begin
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                sd_next   = sd_reg >> 1;
                dcnt_next = dcnt_reg - 1'b1;
            end
            lcs_pkg::OP_EDONE: begin
                err_next = neg_reg ? -signed'({1'b0, err_mag}) : signed'({1'b0, err_mag});
            end
            lcs_pkg::OP_MUL_P: begin
                t_next = TW'(signed'({1'b0, cfg.p_gain}) * err_reg);
            end
            lcs_pkg::OP_MUL_PT: begin
                acc_next = NW'(t_reg * signed'({1'b0, dt_reg}));
            end
            lcs_pkg::OP_MUL_D: begin
                t_next = TW'(signed'({1'b0, cfg.d_gain}) * diff);
            end
            lcs_pkg::OP_ADD_D: begin
                acc_next = acc_reg + (NW'(t_reg) <<< 8);
            end
            lcs_pkg::OP_SUM_L: begin
                nsum_next = spd_sh + acc_reg;
            end
            lcs_pkg::OP_LOAD_DIV: begin
                // |n| / (dt * 2^16), quotient bits above 8 only mean saturation
                rem_next  = abs_nsum;
                neg_next  = nsum_reg[NW-1];
                sd_next   = NW'(dt_reg) << DRV_SHIFT;
                q_next    = '0;
                dcnt_next = DCW'(lcs_pkg::DRV_STEPS - 1);
            end
            lcs_pkg::OP_LDONE: begin
                left_next = drv_val;
                nsum_next = spd_sh - acc_reg;
            end
            lcs_pkg::OP_RDONE: begin
                right_next = drv_val;
            end
            lcs_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    mval_next   = 1'b1;
                    oleft_next  = left_reg;
                    oright_next = right_reg;
                    oerr_next   = lcs_pkg::STEER_W'(err_reg);
                    oseen_next  = seen_reg;
                    prev_next   = err_reg;
                    first_next  = 1'b0;
                    pos_next    = '0;
                    sum_next    = '0;
                    cnt_next    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            first_reg <= 1'b1;
            mval_reg  <= 1'b0;
            dcnt_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            first_reg <= first_next;
            mval_reg  <= mval_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg     <= dt_next;
        err_reg    <= err_next;
        seen_reg   <= seen_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        spd_reg    <= spd_next;
        t_reg      <= t_next;
        acc_reg    <= acc_next;
        nsum_reg   <= nsum_next;
        rem_reg    <= rem_next;
        sd_reg     <= sd_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        oleft_reg  <= oleft_next;
        oright_reg <= oright_next;
        oerr_reg   <= oerr_next;
        oseen_reg  <= oseen_next;
    end

endmodule

[hdl/line_centroid_pd_steering.sv]
// Line-centroid PD steering. Pixels of one scan line stream in one per cycle; white pixels
// (above white_threshold) add a signed position weight to a sum and a count. The pixel with
// tlast set, or the last pixel position, closes the line and starts a microprogram that
// forms the Q8 centroid error, the PD correction and both saturated drives, then posts one
// transaction on the m_axis side; a line with no white pixel skips straight to the post with
// equal reverse drives and zero error. The error quotient is QB bits wide, where
// QB = clog2(256 * (PIXELS_PER_LINE - PIXELS_PER_LINE/2) + 1), and the shared shift-subtract
// divider retires one quotient bit per cycle. No pixel is taken during the line-end program.
// A finished result waits in its output register while the next line streams in.
module line_centroid_pd_steering #(
    parameter int PIXELS_PER_LINE = lcs_pkg::PIXELS_PER_LINE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lcs_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [lcs_pkg::CFG_DW-1:0]        cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // pixel[7:0], elapsed_ms[23:8]
    input  logic                              s_axis_tlast,  // line_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // left_drive[8:0],
                                                             // right_drive[17:9],
                                                             // steer_error[30:18]
    output logic                              m_axis_tuser   // line_seen
);

    lcs_pkg::cfg_t    cfg_reg;
    lcs_pkg::cfg_t    cfg_next;
    lcs_pkg::uword_t  uw;
    lcs_pkg::uflags_t flags;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (lcs_pkg::cfg_idx_t'(cfg_addr))
                lcs_pkg::CFG_THRESH:     cfg_next.white_threshold = cfg_wdata[7:0];
                lcs_pkg::CFG_P_GAIN:     cfg_next.p_gain          = cfg_wdata;
                lcs_pkg::CFG_D_GAIN:     cfg_next.d_gain          = cfg_wdata;
                lcs_pkg::CFG_BASE_SPEED: cfg_next.base_speed      = cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.white_threshold <= lcs_pkg::THRESH_RST;
            cfg_reg.p_gain          <= lcs_pkg::P_GAIN_RST;
            cfg_reg.d_gain          <= lcs_pkg::D_GAIN_RST;
            cfg_reg.base_speed      <= lcs_pkg::SPEED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcs_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uw      (uw)
    );

    lcs_dpath #(
        .PIXELS_PER_LINE (PIXELS_PER_LINE)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .uw       (uw),
        .cfg      (cfg_reg),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .flags    (flags)
    );

endmodule

[hdl/lcs_checker.sv]
module lcs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              s_axis_tlast,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no line: equal reverse drives and zero error
    a_no_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[30:18] == 13'd0 && m_axis_tdata[8:0] == m_axis_tdata[17:9])
        else $error("no-line result malformed");

    // drives stay within -255..255
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[8:0] != 9'h100 && m_axis_tdata[17:9] != 9'h100)
        else $error("drive out of range");

    // closing pixel hands control to the line-end program
    a_line_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("pixel taken during line-end work");

endmodule

bind line_centroid_pd_steering lcs_checker u_lcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
